FILE: rtl/core/pnt_pkg.sv
package pnt_pkg;

    localparam int FracBits   = 16;
    localparam int GradFrac   = 14;
    localparam int TableBits  = 8;
    localparam int MaxOctaves = 15;
    localparam int SumW       = 48;

    typedef enum logic [2:0] {
        FUNC_LOAD_PX   = 3'd0,
        FUNC_LOAD_PY   = 3'd1,
        FUNC_LOAD_PZ   = 3'd2,
        FUNC_LOAD_GRAD = 3'd3,
        FUNC_NOISE     = 3'd4,
        FUNC_TURB      = 3'd5
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAC,
        ST_LOOKUP,
        ST_HASH,
        ST_GRAD,
        ST_MUL,
        ST_TERM,
        ST_OCT,
        ST_DONE
    } state_t;

    // Operand selects for the shared multiplier.
    typedef enum logic [3:0] {
        MS_F2,
        MS_S,
        MS_WXY,
        MS_W,
        MS_GX,
        MS_GY,
        MS_GZ,
        MS_TERM
    } msel_t;

endpackage

FILE: rtl/core/perlin_noise_turbulence.sv
// Steps: a noise item runs the smoothstep on each of the three axes, then the
// work for each of the eight lattice corners, one octave step and one output
// step. A turbulence item repeats the smoothstep, corner and octave steps once
// per octave of the count; a count of zero goes straight to the output step.
// Loads are accepted one per cycle while the core is idle and no result waits.
// One item is in work at a time; the shared multiplier is used six times per
// corner. Synchronous active-low reset clears control state and sets the octave count to 7; tables are not cleared.
module perlin_noise_turbulence
    import pnt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    input  logic [7:0]         s_table_index,
    input  logic [7:0]         s_perm_value,
    input  logic signed [14:0] s_grad_x,
    input  logic signed [14:0] s_grad_y,
    input  logic signed [14:0] s_grad_z,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_noise_value
);

    logic [7:0]  perm_x_mem [256];
    logic [7:0]  perm_y_mem [256];
    logic [7:0]  perm_z_mem [256];
    logic [44:0] grad_mem   [256];

    state_t state_reg, state_next;
    logic [3:0]  oct_cfg_reg;
    logic        turb_reg;
    logic [3:0]  oct_left_reg, oct_idx_reg;
    logic [31:0] pt_reg [3];
    logic [1:0]  ax_reg;
    logic [1:0]  sub_reg;
    logic [2:0]  corner_reg;
    msel_t       mstep_reg;
    logic [16:0] s_reg [3];
    logic [16:0] f2_reg;
    logic [7:0]  px_reg, py_reg, pz_reg;
    logic [7:0]  hash_reg;
    logic [44:0] g_reg;
    logic signed [40:0] dot_reg;
    logic [16:0] wt_reg;
    logic signed [SumW-1:0] nsum_reg, acc_reg;
    logic signed [23:0] out_reg;
    logic        out_valid_reg;

    logic signed [33:0] ma, mb;
    logic signed [67:0] mp;
    logic [15:0] fr [3];
    logic [16:0] w_c [3];
    logic signed [17:0] off_c [3];
    logic [7:0]  cell_lo [3];

    pnt_mul u_mul (.aclk(aclk), .a(ma), .b(mb), .p_reg(mp));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fr[i]      = pt_reg[i][15:0];
            cell_lo[i] = pt_reg[i][23:16];
            w_c[i]     = corner_reg[2-i] ? s_reg[i] : (17'h10000 - s_reg[i]);
            off_c[i]   = corner_reg[2-i] ? ({2'b0, fr[i]} - 18'sh10000)
                                         : {2'b0, fr[i]};
        end
    end

    // Multiplier operands per micro step.
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (mstep_reg)
            MS_F2: begin
                ma = {18'b0, fr[ax_reg]};
                mb = {18'b0, fr[ax_reg]};
            end
            MS_S: begin
                ma = {17'b0, f2_reg};
                mb = 34'sh30000 - {17'b0, fr[ax_reg], 1'b0};
            end
            MS_WXY: begin
                ma = {17'b0, w_c[0]};
                mb = {17'b0, w_c[1]};
            end
            MS_W: begin
                ma = {17'b0, wt_reg};
                mb = {17'b0, w_c[2]};
            end
            MS_GX: begin
                ma = {{19{g_reg[44]}}, g_reg[44:30]};
                mb = {{16{off_c[0][17]}}, off_c[0]};
            end
            MS_GY: begin
                ma = {{19{g_reg[29]}}, g_reg[29:15]};
                mb = {{16{off_c[1][17]}}, off_c[1]};
            end
            MS_GZ: begin
                ma = {{19{g_reg[14]}}, g_reg[14:0]};
                mb = {{16{off_c[2][17]}}, off_c[2]};
            end
            MS_TERM: begin
                ma = {17'b0, wt_reg};
                mb = {{7{dot_reg[40]}}, dot_reg[40:GradFrac]};
            end
            default: ;
        endcase
    end

    logic s_fire, m_fire, is_eval;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign is_eval = (s_func == FUNC_NOISE) || (s_func == FUNC_TURB);
    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_noise_value = out_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            unique case (s_func)
                FUNC_LOAD_PX:   perm_x_mem[s_table_index] <= s_perm_value;
                FUNC_LOAD_PY:   perm_y_mem[s_table_index] <= s_perm_value;
                FUNC_LOAD_PZ:   perm_z_mem[s_table_index] <= s_perm_value;
                FUNC_LOAD_GRAD: grad_mem[s_table_index] <= {s_grad_x, s_grad_y, s_grad_z};
                default: ;
            endcase
        end
        px_reg <= perm_x_mem[cell_lo[0] + {7'b0, corner_reg[2]}];
        py_reg <= perm_y_mem[cell_lo[1] + {7'b0, corner_reg[1]}];
        pz_reg <= perm_z_mem[cell_lo[2] + {7'b0, corner_reg[0]}];
        g_reg  <= grad_mem[hash_reg];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire && is_eval) begin
                state_next = (s_func == FUNC_TURB && s_ready && oct_cfg_reg == 4'd0)
                           ? ST_DONE : ST_FRAC;
            end
            ST_FRAC:   if (ax_reg == 2'd2 && sub_reg == 2'd3) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_HASH;
            ST_HASH:   state_next = ST_GRAD;
            ST_GRAD:   state_next = ST_MUL;
            ST_MUL:    if (mstep_reg == MS_TERM && sub_reg == 2'd1) state_next = ST_TERM;
            ST_TERM:   state_next = (corner_reg == 3'd7) ? ST_OCT : ST_LOOKUP;
            ST_OCT:    state_next = (oct_left_reg == 4'd1) ? ST_DONE : ST_FRAC;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    logic signed [SumW-1:0] acc_fin, acc_abs;
    always_comb begin
        acc_fin = acc_reg;
        acc_abs = acc_fin[SumW-1] ? -acc_fin : acc_fin;
        if (!turb_reg) acc_abs = acc_fin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            oct_cfg_reg   <= 4'd7;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) oct_cfg_reg <= cfg_wdata;
            if (state_reg == ST_DONE) out_valid_reg <= 1'b1;
            else if (m_fire) out_valid_reg <= 1'b0;
        end
    end

    // Datapath; sub_reg counts the multiplier latency within a step.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                pt_reg[0]    <= s_point_x;
                pt_reg[1]    <= s_point_y;
                pt_reg[2]    <= s_point_z;
                turb_reg     <= (s_func == FUNC_TURB);
                oct_left_reg <= (s_func == FUNC_TURB) ? oct_cfg_reg : 4'd1;
                oct_idx_reg  <= '0;
                acc_reg      <= '0;
                ax_reg       <= '0;
                sub_reg      <= '0;
                mstep_reg    <= MS_F2;
                nsum_reg     <= '0;
                corner_reg   <= '0;
            end
            ST_FRAC: begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd0) mstep_reg <= MS_F2;
                if (sub_reg == 2'd1) begin
                    f2_reg    <= mp[32:16];
                    mstep_reg <= MS_S;
                end
                if (sub_reg == 2'd3) begin
                    s_reg[ax_reg] <= mp[32:16];
                    ax_reg        <= ax_reg + 2'd1;
                    mstep_reg     <= MS_F2;
                end
            end
            ST_LOOKUP: ;
            ST_HASH:   hash_reg <= px_reg ^ py_reg ^ pz_reg;
            ST_GRAD: begin
                mstep_reg <= MS_WXY;
                sub_reg   <= '0;
                dot_reg   <= '0;
            end
            ST_MUL: begin
                sub_reg <= (sub_reg == 2'd1) ? 2'd0 : sub_reg + 2'd1;
                if (sub_reg == 2'd1) begin
                    unique case (mstep_reg)
                        MS_WXY: begin wt_reg <= mp[32:16]; mstep_reg <= MS_W; end
                        MS_W:   begin wt_reg <= mp[32:16]; mstep_reg <= MS_GX; end
                        MS_GX:  begin dot_reg <= dot_reg + mp[40:0]; mstep_reg <= MS_GY; end
                        MS_GY:  begin dot_reg <= dot_reg + mp[40:0]; mstep_reg <= MS_GZ; end
                        MS_GZ:  begin dot_reg <= dot_reg + mp[40:0]; mstep_reg <= MS_TERM; end
                        default: nsum_reg <= nsum_reg + SumW'(mp >>> FracBits);
                    endcase
                end
            end
            ST_TERM: begin
                corner_reg <= corner_reg + 3'd1;
                mstep_reg  <= MS_WXY;
            end
            ST_OCT: begin
                acc_reg      <= acc_reg + (nsum_reg >>> oct_idx_reg);
                nsum_reg     <= '0;
                oct_idx_reg  <= oct_idx_reg + 4'd1;
                oct_left_reg <= oct_left_reg - 4'd1;
                for (int i = 0; i < 3; i++) pt_reg[i] <= {pt_reg[i][30:0], 1'b0};
                ax_reg       <= '0;
                sub_reg      <= '0;
                corner_reg   <= '0;
                mstep_reg    <= MS_F2;
            end
            ST_DONE: begin
                if (acc_abs > 48'sd8388607)       out_reg <= 24'sh7FFFFF;
                else if (acc_abs < -48'sd8388608) out_reg <= 24'sh800000;
                else                              out_reg <= acc_abs[23:0];
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> m_valid) else $error("result lost");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_noise_value)) else $error("result changed");
`endif

endmodule

FILE: rtl/core/pnt_mul.sv
module pnt_mul
    import pnt_pkg::*;
(
    input  logic               aclk,
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic signed [67:0] p_reg
);

    // Registered shared multiplier; every product of the datapath passes here.
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule
